FILE: hdl/sht_pkg.sv
// shared types, constants and codes for the sorted hash table search unit
`default_nettype none

package sht_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int NCOUNT_W    = ADDR_W + 1;

  localparam int COUNT_W     = 11;
  localparam int INDEX_W     = 10;
  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [WORD_W-1:0] FALLBACK_RESET = 32'h9bb9_ccc3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_RECORD_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_LABEL = 2'd1;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] record_index;
    logic [WORD_W-1:0]  record_hash;
    logic [WORD_W-1:0]  record_offset;
    logic [WORD_W-1:0]  label;
    logic               use_fallback;
  } sht_in_t;

  typedef struct packed {
    logic              found;
    logic              fell_back;
    logic [WORD_W-1:0] string_offset;
  } sht_out_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_MID_INIT,
    RD_MID_NEXT,
    RD_BOT,
    RD_TOP
  } sht_rd_sel_t;

  typedef struct packed {
    logic        mem_write;
    logic        key_load;
    logic        key_fallback;
    logic        init;
    logic        step;
    logic        step_saved;
    logic        save_flags;
    sht_rd_sel_t rd_sel;
    logic        res_load;
    logic        res_found;
    logic        res_fell_back;
  } sht_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic use_fallback;
    logic empty;
    logic hit;
    logic span_small;
    logic span_tiny;
  } sht_stat_t;

endpackage

`default_nettype wire

FILE: hdl/sht_if.sv
// handshake channel interfaces: request, response and register write
`default_nettype none

interface sht_in_if;
  logic            valid;
  logic            ready;
  sht_pkg::sht_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sht_out_if;
  logic             valid;
  logic             ready;
  sht_pkg::sht_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sht_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sht_pkg::CFG_INDEX_W-1:0] index;
  logic [sht_pkg::WORD_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sorted_hash_table_search_unit.sv
// top level: sorted hash table with binary search lookup and fallback retry
// a load beat writes one table entry and loads are accepted back to back
// a search has one set-up state, then one midpoint probe per step while the span is three or
// more, then three probes (mid, bot, top), six if the span ends at two
// a fallback retry runs the search again with the fallback label
// a result stalled by rsp.ready waits in a hold state; reset clears the control state and config registers only
`default_nettype none

module sorted_hash_table_search_unit (
  input  wire logic clk,
  input  wire logic rst,
  sht_in_if.sink    req,
  sht_out_if.source rsp,
  sht_cfg_if.sink   cfg
);

  sht_pkg::sht_cmd_t  cmd;
  sht_pkg::sht_stat_t stat;
  logic               ctrl_in_ready;
  logic               ctrl_out_valid;

  assign req.ready = ctrl_in_ready;
  assign rsp.valid = ctrl_out_valid;

  sht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (ctrl_in_ready),
    .out_valid (ctrl_out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sht_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (req.payload),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (rsp.payload)
  );

  a_lookup_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.payload.command == sht_pkg::CMD_LOOKUP |=> !req.ready)
    else $error("lookup beat did not start a search");

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.payload.command == sht_pkg::CMD_LOAD |=> req.ready)
    else $error("load beat stalled the request side");

  a_fallback_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.fell_back |-> rsp.payload.found)
    else $error("fell_back set on a miss");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.payload.found |-> rsp.payload.string_offset == '0)
    else $error("miss carries a non-zero offset");

endmodule

`default_nettype wire

FILE: hdl/sht_datapath.sv
// table memories, search bounds, key, config registers and result register
`default_nettype none

module sht_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  sht_cfg_if.sink                cfg,
  input  wire sht_pkg::sht_in_t  in_data,
  input  wire sht_pkg::sht_cmd_t cmd,
  output sht_pkg::sht_stat_t     stat,
  output sht_pkg::sht_out_t      out_data
);

  localparam logic [sht_pkg::ADDR_W-1:0] SPAN_ENDS = sht_pkg::ADDR_W'(3);
  localparam logic [sht_pkg::ADDR_W-1:0] SPAN_LAST = sht_pkg::ADDR_W'(2);

  logic [sht_pkg::COUNT_W-1:0] record_count;
  logic [sht_pkg::WORD_W-1:0]  fallback_label;

  logic [sht_pkg::WORD_W-1:0] hash_store   [sht_pkg::MAX_RECORDS];
  logic [sht_pkg::WORD_W-1:0] offset_store [sht_pkg::MAX_RECORDS];

  logic [sht_pkg::WORD_W-1:0] rd_hash;
  logic [sht_pkg::WORD_W-1:0] rd_offset;
  logic [sht_pkg::WORD_W-1:0] key;
  logic                       use_fallback;
  logic [sht_pkg::ADDR_W-1:0] bot;
  logic [sht_pkg::ADDR_W-1:0] top;
  logic                       saved_gt;
  logic                       saved_lt;

  logic [sht_pkg::ADDR_W-1:0] bot_next;
  logic [sht_pkg::ADDR_W-1:0] top_next;
  logic [sht_pkg::ADDR_W-1:0] mid;
  logic [sht_pkg::ADDR_W-1:0] mid_next;
  logic [sht_pkg::ADDR_W-1:0] span;
  logic [sht_pkg::ADDR_W-1:0] top_init;
  logic [sht_pkg::ADDR_W-1:0] rd_addr;
  logic [sht_pkg::ADDR_W-1:0] wr_addr;
  logic [sht_pkg::NCOUNT_W-1:0] n_clamped;
  logic                       rd_en;
  logic                       wr_en;
  logic                       live_gt;
  logic                       live_lt;
  logic                       step_gt;
  logic                       step_lt;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count   <= '0;
      fallback_label <= sht_pkg::FALLBACK_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == sht_pkg::REG_RECORD_COUNT) begin
        record_count <= cfg.data[sht_pkg::COUNT_W-1:0];
      end else if (cfg.index == sht_pkg::REG_FALLBACK_LABEL) begin
        fallback_label <= cfg.data;
      end
    end
  end

  // counts above the table size search the whole table
  assign n_clamped = (32'(record_count) > 32'(sht_pkg::MAX_RECORDS))
                   ? sht_pkg::NCOUNT_W'(sht_pkg::MAX_RECORDS)
                   : sht_pkg::NCOUNT_W'(record_count);
  assign top_init  = sht_pkg::ADDR_W'(n_clamped - 1'b1);

  assign mid  = sht_pkg::ADDR_W'(({1'b0, bot} + {1'b0, top}) >> 1);
  assign span = top - bot;

  assign live_gt = rd_hash > key;
  assign live_lt = rd_hash < key;
  assign step_gt = cmd.step_saved ? saved_gt : live_gt;
  assign step_lt = cmd.step_saved ? saved_lt : live_lt;

  always_comb begin
    bot_next = bot;
    top_next = top;
    if (cmd.init) begin
      bot_next = '0;
      top_next = top_init;
    end else if (cmd.step) begin
      if (step_gt) begin
        top_next = mid;
      end
      if (step_lt) begin
        bot_next = mid;
      end
    end
  end

  assign mid_next = sht_pkg::ADDR_W'(({1'b0, bot_next} + {1'b0, top_next}) >> 1);

  always_comb begin
    unique case (cmd.rd_sel)
      sht_pkg::RD_MID_INIT: rd_addr = top_init >> 1;
      sht_pkg::RD_MID_NEXT: rd_addr = mid_next;
      sht_pkg::RD_BOT:      rd_addr = bot;
      sht_pkg::RD_TOP:      rd_addr = top;
      default:              rd_addr = mid;
    endcase
  end

  assign rd_en   = cmd.rd_sel != sht_pkg::RD_NONE;
  assign wr_addr = sht_pkg::ADDR_W'(in_data.record_index);
  assign wr_en   = cmd.mem_write &&
                   (32'(in_data.record_index) < 32'(sht_pkg::MAX_RECORDS));

  // both stores share the probe address, so the offset arrives with its hash
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hash_store[wr_addr] <= in_data.record_hash;
    end
    if (rd_en) begin
      rd_hash <= hash_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      offset_store[wr_addr] <= in_data.record_offset;
    end
    if (rd_en) begin
      rd_offset <= offset_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= cmd.key_fallback ? fallback_label : in_data.label;
    end
    if (cmd.key_load && !cmd.key_fallback) begin
      use_fallback <= in_data.use_fallback;
    end
    bot <= bot_next;
    top <= top_next;
    if (cmd.save_flags) begin
      saved_gt <= live_gt;
      saved_lt <= live_lt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.found         <= cmd.res_found;
      out_data.fell_back     <= cmd.res_found & cmd.res_fell_back;
      out_data.string_offset <= cmd.res_found ? rd_offset : '0;
    end
  end

  assign stat.is_lookup    = in_data.command == sht_pkg::CMD_LOOKUP;
  assign stat.use_fallback = use_fallback;
  assign stat.empty        = record_count == '0;
  assign stat.hit          = rd_hash == key;
  assign stat.span_small   = span < SPAN_ENDS;
  assign stat.span_tiny    = span < SPAN_LAST;

endmodule

`default_nettype wire

FILE: hdl/sht_ctrl.sv
// search sequencer: probe order, fallback retry and result handoff
`default_nettype none

module sht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sht_pkg::sht_stat_t stat,
  output sht_pkg::sht_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE,
    START,
    CMP_MID,
    CMP_BOT,
    CMP_TOP,
    WAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   fb;
  logic   fb_next;
  logic   hit_q;
  logic   hit_q_next;
  logic   out_valid_next;
  logic   out_free;
  logic   finish;
  logic   finish_hit;

  assign in_ready = state == IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = sht_pkg::RD_NONE;
    state_next     = state;
    fb_next        = fb;
    hit_q_next     = hit_q;
    finish         = 1'b0;
    finish_hit     = 1'b0;

    unique case (state)
      IDLE: begin
        if (in_valid) begin
          if (stat.is_lookup) begin
            cmd.key_load = 1'b1;
            fb_next      = 1'b0;
            state_next   = START;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      START: begin
        if (stat.empty) begin
          finish = 1'b1;
        end else begin
          cmd.init   = 1'b1;
          cmd.rd_sel = sht_pkg::RD_MID_INIT;
          state_next = CMP_MID;
        end
      end
      CMP_MID: begin
        cmd.save_flags = 1'b1;
        if (stat.hit) begin
          finish     = 1'b1;
          finish_hit = 1'b1;
        end else if (stat.span_small) begin
          cmd.rd_sel = sht_pkg::RD_BOT;
          state_next = CMP_BOT;
        end else begin
          cmd.step   = 1'b1;
          cmd.rd_sel = sht_pkg::RD_MID_NEXT;
        end
      end
      CMP_BOT: begin
        if (stat.hit) begin
          finish     = 1'b1;
          finish_hit = 1'b1;
        end else begin
          cmd.rd_sel = sht_pkg::RD_TOP;
          state_next = CMP_TOP;
        end
      end
      CMP_TOP: begin
        if (stat.hit) begin
          finish     = 1'b1;
          finish_hit = 1'b1;
        end else if (stat.span_tiny) begin
          // midpoint has met bot: this search misses
          if (stat.use_fallback && !fb) begin
            cmd.key_load     = 1'b1;
            cmd.key_fallback = 1'b1;
            fb_next          = 1'b1;
            state_next       = START;
          end else begin
            finish = 1'b1;
          end
        end else begin
          cmd.step       = 1'b1;
          cmd.step_saved = 1'b1;
          cmd.rd_sel     = sht_pkg::RD_MID_NEXT;
          state_next     = CMP_MID;
        end
      end
      WAIT: begin
        if (out_free) begin
          cmd.res_load      = 1'b1;
          cmd.res_found     = hit_q;
          cmd.res_fell_back = fb;
          state_next        = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase

    // an empty table misses at once, even with a fallback request: no retry is run
    if (finish) begin
      if (out_free) begin
        cmd.res_load      = 1'b1;
        cmd.res_found     = finish_hit;
        cmd.res_fell_back = fb;
        state_next        = IDLE;
      end else begin
        hit_q_next = finish_hit;
        state_next = WAIT;
      end
    end

    out_valid_next = out_valid;
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      fb        <= 1'b0;
      hit_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fb        <= fb_next;
      hit_q     <= hit_q_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: sim/sorted_hash_table_search_unit_test.sv
// self-checking testbench for the sorted hash table search unit: loads, lookups, registers
`timescale 1ns / 1ps

module sorted_hash_table_search_unit_test;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int QUIET_CYCLES = 64;
  localparam int RANDOM_BEATS = 650;
  localparam int MAX_RELOAD   = 200;
  localparam int COUNT_TOP    = (1 << sht_pkg::COUNT_W) - 1;
  localparam int TIMEOUT_NS   = 8_000_000;

  localparam logic [sht_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [sht_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_SKIP, RX_BLOCK} rx_mode_t;
  typedef enum int {TBL_SORTED, TBL_REPEATS, TBL_SCRAMBLED} tbl_shape_t;

  logic clk;
  logic rst;

  sht_in_if  req ();
  sht_out_if rsp ();
  sht_cfg_if cfg ();

  sorted_hash_table_search_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // local copy of the table and the registers
  logic [sht_pkg::WORD_W-1:0]  hash_mirror   [sht_pkg::MAX_RECORDS];
  logic [sht_pkg::WORD_W-1:0]  offset_mirror [sht_pkg::MAX_RECORDS];
  logic [sht_pkg::COUNT_W-1:0] count_mirror;
  logic [sht_pkg::WORD_W-1:0]  fallback_mirror;

  sht_pkg::sht_out_t lookup_answers [$];
  int                error_count  = 0;
  int                random_beats = 0;
  int                burst_left   = 0;
  rx_mode_t          rx_mode      = RX_OPEN;
  int                rx_mode_left = 0;
  int unsigned       rx_tick      = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic probe_table(input logic [sht_pkg::WORD_W-1:0] key,
                                       output int unsigned slot);
    int unsigned span, bot, top, mid;
    logic        hit, done;
    slot = 0;
    hit  = 1'b0;
    span = (int'(count_mirror) > sht_pkg::MAX_RECORDS) ? sht_pkg::MAX_RECORDS
                                                       : int'(count_mirror);
    done = (span == 0);
    bot  = 0;
    top  = (span == 0) ? 0 : span - 1;
    while (!done) begin
      mid = (bot + top) >> 1;
      if (hash_mirror[mid] == key) begin
        slot = mid;
        hit  = 1'b1;
        done = 1'b1;
      // once the span is under three both bounds are checked as well
      end else if (top - bot < 3 && hash_mirror[bot] == key) begin
        slot = bot;
        hit  = 1'b1;
        done = 1'b1;
      end else if (top - bot < 3 && hash_mirror[top] == key) begin
        slot = top;
        hit  = 1'b1;
        done = 1'b1;
      end else if (mid == bot) begin
        done = 1'b1;
      end else begin
        if (hash_mirror[mid] > key) top = mid;
        if (hash_mirror[mid] < key) bot = mid;
      end
    end
    return hit;
  endfunction

  function automatic sht_pkg::sht_out_t predict_lookup(input sht_pkg::sht_in_t beat);
    sht_pkg::sht_out_t ans;
    int unsigned       slot;
    ans = '0;
    if (probe_table(beat.label, slot)) begin
      ans.found         = 1'b1;
      ans.string_offset = offset_mirror[slot];
    end else if (beat.use_fallback && probe_table(fallback_mirror, slot)) begin
      ans.found         = 1'b1;
      ans.fell_back     = 1'b1;
      ans.string_offset = offset_mirror[slot];
    end
    return ans;
  endfunction

  function automatic sht_pkg::sht_in_t make_load(input int unsigned slot,
                                                 input logic [sht_pkg::WORD_W-1:0] hash,
                                                 input logic [sht_pkg::WORD_W-1:0] offset);
    sht_pkg::sht_in_t beat;
    beat.command       = sht_pkg::CMD_LOAD;
    beat.record_index  = sht_pkg::INDEX_W'(slot);
    beat.record_hash   = hash;
    beat.record_offset = offset;
    beat.label         = $urandom;
    beat.use_fallback  = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  function automatic sht_pkg::sht_in_t make_lookup(input logic [sht_pkg::WORD_W-1:0] label,
                                                   input logic retry);
    sht_pkg::sht_in_t beat;
    beat.command       = sht_pkg::CMD_LOOKUP;
    beat.record_index  = sht_pkg::INDEX_W'($urandom);
    beat.record_hash   = $urandom;
    beat.record_offset = $urandom;
    beat.label         = label;
    beat.use_fallback  = retry;
    return beat;
  endfunction

  task automatic report_mismatch(input string what, input logic [sht_pkg::WORD_W-1:0] got,
                                 input logic [sht_pkg::WORD_W-1:0] want);
    error_count++;
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_answer(input sht_pkg::sht_out_t got);
    sht_pkg::sht_out_t want;
    if (lookup_answers.size() == 0) begin
      report_mismatch("result beat with no lookup pending", got.string_offset, '0);
    end else begin
      want = lookup_answers.pop_front();
      if (got.found !== want.found)
        report_mismatch("found", sht_pkg::WORD_W'(got.found), sht_pkg::WORD_W'(want.found));
      if (got.fell_back !== want.fell_back)
        report_mismatch("fell_back", sht_pkg::WORD_W'(got.fell_back),
                        sht_pkg::WORD_W'(want.fell_back));
      if (got.string_offset !== want.string_offset)
        report_mismatch("string_offset", got.string_offset, want.string_offset);
    end
  endtask

  // result side: check accepted beats, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) check_answer(rsp.payload);
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:  rsp.ready <= 1'b1;
      RX_COIN:  rsp.ready <= 1'($urandom_range(0, 1));
      RX_SKIP:  rsp.ready <= (rx_tick % 5) != 2;
      default:  rsp.ready <= (rx_tick % 16) >= 12;
    endcase
    rx_tick++;
  end

  task automatic send_beat(input sht_pkg::sht_in_t beat);
    int gap;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid   <= 1'b1;
    req.payload <= beat;
    do begin
      @(posedge clk);
    end while (!req.ready);
    burst_left--;
    if (beat.command == sht_pkg::CMD_LOAD) begin
      hash_mirror[beat.record_index]   = beat.record_hash;
      offset_mirror[beat.record_index] = beat.record_offset;
    end else begin
      lookup_answers.push_back(predict_lookup(beat));
    end
  endtask

  task automatic write_reg(input logic [sht_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sht_pkg::WORD_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      sht_pkg::REG_RECORD_COUNT:   count_mirror    = value[sht_pkg::COUNT_W-1:0];
      sht_pkg::REG_FALLBACK_LABEL: fallback_mirror = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain all lookups, then give a trailing load time to land
  task automatic settle();
    req.valid <= 1'b0;
    while (lookup_answers.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // every entry gets written once so no lookup can touch an unwritten slot
  task automatic test_table_fill();
    logic [32:0] acc;
    acc = 33'($urandom_range(0, 1000));
    for (int i = 0; i < sht_pkg::MAX_RECORDS; i++) begin
      send_beat(make_load(i, acc[sht_pkg::WORD_W-1:0], $urandom));
      acc = acc + 33'($urandom_range(1, 4_000_000));
    end
  endtask

  task automatic test_reset_fallback();
    // count is zero out of reset, so even a retry misses
    send_beat(make_lookup(sht_pkg::FALLBACK_RESET, 1'b1));
    settle();
    write_reg(sht_pkg::REG_RECORD_COUNT, sht_pkg::WORD_W'(4));
    send_beat(make_load(0, 32'h0000_0000, 32'hFFFF_FFFF));
    send_beat(make_load(1, 32'h0000_0005, 32'h0000_0000));
    send_beat(make_load(2, sht_pkg::FALLBACK_RESET, $urandom));
    send_beat(make_load(3, 32'hFFFF_FFFF, $urandom));
    // miss on the label, hit on the fallback label left from reset
    send_beat(make_lookup(32'h0000_0007, 1'b1));
    send_beat(make_lookup(32'h0000_0000, 1'b0));
    send_beat(make_lookup(32'hFFFF_FFFF, 1'b0));
    send_beat(make_lookup(32'h0000_0005, 1'b1));
    send_beat(make_lookup(32'h0000_0007, 1'b0));
  endtask

  task automatic test_fallback_paths();
    settle();
    write_reg(sht_pkg::REG_FALLBACK_LABEL, 32'h0000_0005);
    send_beat(make_lookup(32'h0000_0006, 1'b1));
    send_beat(make_lookup(32'h0000_0005, 1'b1));
    settle();
    // fallback label absent: both searches miss
    write_reg(sht_pkg::REG_FALLBACK_LABEL, 32'h0000_0006);
    send_beat(make_lookup(32'h0000_0006, 1'b1));
    send_beat(make_lookup(32'h8000_0000, 1'b1));
  endtask

  task automatic test_count_limits();
    settle();
    write_reg(sht_pkg::REG_RECORD_COUNT, sht_pkg::WORD_W'(1));
    send_beat(make_lookup(32'h0000_0000, 1'b0));
    send_beat(make_lookup(32'h0000_0005, 1'b1));
    settle();
    // above the table size the count is clamped
    write_reg(sht_pkg::REG_RECORD_COUNT, sht_pkg::WORD_W'(COUNT_TOP));
    send_beat(make_lookup(hash_mirror[sht_pkg::MAX_RECORDS-1], 1'b0));
    send_beat(make_lookup(hash_mirror[700], 1'b1));
    settle();
    write_reg(sht_pkg::REG_RECORD_COUNT, sht_pkg::WORD_W'(sht_pkg::MAX_RECORDS));
    send_beat(make_lookup(hash_mirror[sht_pkg::MAX_RECORDS-1], 1'b0));
    send_beat(make_lookup(hash_mirror[512], 1'b0));
    send_beat(make_lookup($urandom, 1'b1));
  endtask

  task automatic test_spare_reg_index();
    settle();
    write_reg(REG_SPARE_2, $urandom);
    write_reg(REG_SPARE_3, $urandom);
    send_beat(make_lookup(32'h0000_0007, 1'b1));
    send_beat(make_lookup(hash_mirror[1000], 1'b0));
  endtask

  task automatic test_random_searches();
    logic [sht_pkg::WORD_W-1:0] fresh_hash [MAX_RELOAD];
    tbl_shape_t                 shape;
    int unsigned                count, reload, span, slot, roll, lookups;
    logic [32:0]                acc;
    logic [sht_pkg::WORD_W-1:0] step_cap, step, fb, label;
    bit                         first_phase;
    first_phase = 1'b1;
    while (random_beats < RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (first_phase)    count = sht_pkg::MAX_RECORDS;
      else if (roll < 4)  count = 0;
      else if (roll < 60) count = $urandom_range(1, 8);
      else if (roll < 80) count = $urandom_range(9, 40);
      else if (roll < 88) count = $urandom_range(41, MAX_RELOAD);
      else if (roll < 94) count = sht_pkg::MAX_RECORDS;
      else if (roll < 97) count = $urandom_range(sht_pkg::MAX_RECORDS + 1, COUNT_TOP);
      else                count = $urandom_range(MAX_RELOAD + 1, sht_pkg::MAX_RECORDS - 1);
      first_phase = 1'b0;
      // large counts search whatever the table already holds
      reload = (count <= MAX_RELOAD) ? count : 0;
      span   = (count == 0) ? 1
             : ((count > sht_pkg::MAX_RECORDS) ? sht_pkg::MAX_RECORDS : count);

      roll  = $urandom_range(0, 99);
      shape = (roll < 70) ? TBL_SORTED : ((roll < 85) ? TBL_REPEATS : TBL_SCRAMBLED);
      acc      = 33'($urandom >> $urandom_range(0, 12));
      step_cap = sht_pkg::WORD_W'((33'h1_0000_0000 - acc) / 33'(reload + 1));
      for (int i = 0; i < reload; i++) begin
        if (shape == TBL_SCRAMBLED) begin
          fresh_hash[i] = $urandom;
        end else begin
          fresh_hash[i] = (acc > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                  : acc[sht_pkg::WORD_W-1:0];
          step = $urandom_range(1, step_cap);
          if (shape == TBL_REPEATS && $urandom_range(0, 2) == 0) step = '0;
          acc = acc + 33'(step);
        end
      end

      if ($urandom_range(0, 1) == 0) fb = $urandom;
      else if (reload > 0)           fb = fresh_hash[$urandom_range(0, reload - 1)];
      else                           fb = hash_mirror[$urandom_range(0, span - 1)];

      settle();
      write_reg(sht_pkg::REG_RECORD_COUNT, sht_pkg::WORD_W'(count));
      write_reg(sht_pkg::REG_FALLBACK_LABEL, fb);

      for (int i = 0; i < reload; i++) begin
        send_beat(make_load(i, fresh_hash[i], $urandom));
        random_beats++;
      end

      lookups = $urandom_range(8, 40);
      repeat (lookups) begin
        slot = $urandom_range(0, span - 1);
        roll = $urandom_range(0, 19);
        if (roll < 9)       label = hash_mirror[slot];
        else if (roll < 12) label = hash_mirror[slot] + 32'd1;
        else if (roll < 14) label = hash_mirror[slot] - 32'd1;
        else if (roll < 16) label = $urandom;
        else if (roll < 18) label = fb;
        else                label = roll[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
        send_beat(make_lookup(label, 1'($urandom_range(0, 1))));
        random_beats++;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.payload = '0;
    rsp.ready   = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    count_mirror    = '0;
    fallback_mirror = sht_pkg::FALLBACK_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_reset_fallback();
    test_fallback_paths();
    test_count_limits();
    test_spare_reg_index();
    test_random_searches();

    settle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sht_pkg.sv
hdl/sht_if.sv
hdl/sht_datapath.sv
hdl/sht_ctrl.sv
hdl/sorted_hash_table_search_unit.sv
sim/sorted_hash_table_search_unit_test.sv
